/* src/assert_macros.svh */
// Assertion macros shared by the voice allocator RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/mva_pkg.sv */
// Types, constants and helpers for the MIDI voice allocator.
// No dependencies; used by every module of the block.
package mva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;

    localparam logic [1:0] ACT_IGNORED   = 2'd0;
    localparam logic [1:0] ACT_STARTED   = 2'd1;
    localparam logic [1:0] ACT_RELEASED  = 2'd2;
    localparam logic [1:0] ACT_NOT_FOUND = 2'd3;

    typedef logic [VIDX_W-1:0] vidx_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] first_data;
        logic [7:0] second_data;
    } mva_req_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] voice;
        logic [6:0] note;
        logic [6:0] velocity;
    } mva_rsp_t;

    // Write of a started note into one voice cell.
    typedef struct packed {
        logic       en;
        vidx_t      voice;
        logic [6:0] note;
    } mva_wr_t;

    // Release search token travelling down the cell chain.
    typedef struct packed {
        logic       valid;
        logic [6:0] note;
    } mva_tok_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } mva_state_t;

    // The reported voice field is three bits; wider indexes keep their low bits.
    function automatic logic [2:0] to_voice(input vidx_t idx);
        logic [VIDX_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

    function automatic vidx_t next_ptr(input vidx_t ptr);
        vidx_t res;
        if (ptr == vidx_t'(NUM_VOICES - 1)) begin
            res = '0;
        end
        else begin
            res = ptr + vidx_t'(1);
        end
        return res;
    endfunction

endpackage

/* src/mva_cell.sv */
// One voice cell: holds the note and active flag of a single voice.
// Depends on mva_pkg. Passes the release search token to the next cell.
module mva_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  mva_pkg::vidx_t    index,
    input  mva_pkg::mva_wr_t  wr,
    input  mva_pkg::mva_tok_t tok_in,
    output mva_pkg::mva_tok_t tok_out,
    output logic              hit
);
    import mva_pkg::*;

    logic       active_reg;
    logic       active_next;
    logic [6:0] note_reg;
    logic [6:0] note_next;
    mva_tok_t   tok_reg;
    mva_tok_t   tok_next;
    logic       wr_here;

    assign wr_here = wr.en && (wr.voice == index);
    assign hit     = tok_in.valid && active_reg && (note_reg == tok_in.note);
    assign tok_out = tok_reg;

    always_comb
    begin
        active_next = active_reg;
        note_next   = note_reg;
        if (wr_here) begin
            active_next = 1'b1;
            note_next   = wr.note;
        end
        else if (hit) begin
            active_next = 1'b0;
        end
        // A matching cell consumes the token so lower indexes win.
        tok_next.valid = tok_in.valid && !hit;
        tok_next.note  = tok_in.note;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else begin
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
    end

endmodule

/* src/mva_ctrl.sv */
// Request decoder, round-robin pointer, search sequencer and result register.
// Depends on mva_pkg; drives the cell chain write bus and search token.
module mva_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mva_pkg::mva_req_t             req,
    output logic                          busy,
    output logic                          done,
    output mva_pkg::mva_rsp_t             result,
    output mva_pkg::mva_wr_t              wr,
    output mva_pkg::mva_tok_t             tok,
    input  logic [mva_pkg::NUM_VOICES-1:0] hit
);
    import mva_pkg::*;

    mva_state_t state_reg;
    mva_state_t state_next;
    vidx_t      ptr_reg;
    vidx_t      ptr_next;
    vidx_t      cnt_reg;
    vidx_t      cnt_next;
    logic [6:0] note_reg;
    logic [6:0] note_next;
    logic       done_reg;
    logic       done_next;
    mva_rsp_t   result_reg;
    mva_rsp_t   result_next;
    logic [3:0] kind;
    logic       data_ok;
    logic       accept;

    assign kind    = req.status_byte[7:4];
    assign data_ok = !req.first_data[7] && !req.second_data[7];
    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        note_next   = note_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr.en       = 1'b0;
        wr.voice    = ptr_reg;
        wr.note     = req.first_data[6:0];
        tok.valid   = 1'b0;
        tok.note    = note_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    result_next.action   = ACT_IGNORED;
                    result_next.voice    = 3'd0;
                    result_next.note     = req.first_data[6:0];
                    result_next.velocity = 7'd0;
                    done_next            = 1'b1;
                    if (data_ok) begin
                        case (kind)
                            KIND_NOTE_ON:
                            begin
                                if (req.second_data != 8'd0) begin
                                    wr.en                = 1'b1;
                                    result_next.action   = ACT_STARTED;
                                    result_next.voice    = to_voice(ptr_reg);
                                    result_next.velocity = req.second_data[6:0];
                                    ptr_next             = next_ptr(ptr_reg);
                                end
                                else begin
                                    // Zero velocity is a release.
                                    done_next  = 1'b0;
                                    state_next = ST_SCAN;
                                    cnt_next   = '0;
                                    note_next  = req.first_data[6:0];
                                end
                            end
                            KIND_NOTE_OFF:
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SCAN;
                                cnt_next   = '0;
                                note_next  = req.first_data[6:0];
                            end
                            KIND_CTRL:
                            begin
                                result_next.action = ACT_IGNORED;
                            end
                            default:
                            begin
                                result_next.action = ACT_IGNORED;
                            end
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                // The token reaches cell cnt_reg in this cycle.
                tok.valid            = (cnt_reg == '0);
                result_next.note     = note_reg;
                result_next.velocity = 7'd0;
                result_next.voice    = 3'd0;
                if (|hit) begin
                    result_next.action = ACT_RELEASED;
                    result_next.voice  = to_voice(cnt_reg);
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                    ptr_next           = next_ptr(ptr_reg);
                end
                else if (cnt_reg == vidx_t'(NUM_VOICES - 1)) begin
                    result_next.action = ACT_NOT_FOUND;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                    ptr_next           = next_ptr(ptr_reg);
                end
                else begin
                    cnt_next = cnt_reg + vidx_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg   <= note_next;
        result_reg <= result_next;
    end

endmodule

/* src/midi_voice_allocator.sv */
// Top level of the MIDI voice allocator: controller plus a chain of voice cells.
// Depends on mva_pkg, mva_ctrl, mva_cell and assert_macros.svh.
//
//  channel   ports                    qualifier          direction
//  request   req (mva_req_t)          start && !busy     in
//  result    result (mva_rsp_t)       done, one cycle    out
//
// Ignored messages and note starts give their result in the cycle after the request.
// A release walks a token down the cells, one cell per cycle, and ends at the
// first voice that matches, or after the last cell when no voice matches.
// busy is high during that walk; reset clears all voices and the pointer.
// The result is shown for one cycle and cannot be held off by the receiver.
`include "assert_macros.svh"

module midi_voice_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mva_pkg::mva_req_t req,
    output logic              busy,
    output logic              done,
    output mva_pkg::mva_rsp_t result
);
    import mva_pkg::*;

    mva_wr_t               wr;
    mva_tok_t              tok_chain [NUM_VOICES+1];
    logic [NUM_VOICES-1:0] hit;

    mva_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result),
        .wr     (wr),
        .tok    (tok_chain[0]),
        .hit    (hit)
    );

    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
        mva_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (vidx_t'(g)),
            .wr      (wr),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1]),
            .hit     (hit[g])
        );
    end

    // Only one cell can hold the token, so at most one cell matches.
    `ASSERT_IMPLIES(a_hit_onehot, clk, rst_n, 1'b1, $onehot0(hit))
    // Cells only match during a release walk.
    `ASSERT_IMPLIES(a_hit_busy, clk, rst_n, |hit, busy)
    // A token leaving the end of the chain comes from a walk that found nothing.
    `ASSERT_IMPLIES(a_tok_exit, clk, rst_n, tok_chain[NUM_VOICES].valid, done && !busy)
    // A started voice is reported in the following cycle.
    `ASSERT_NEXT(a_start_done, clk, rst_n, wr.en, done && (result.action == ACT_STARTED))

endmodule
